// ----- src/sactc_pkg.sv -----
package sactc_pkg;

  localparam int SETS      = 256;
  localparam int WAYS      = 8;
  localparam int ADDR_BITS = 32;
  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = $clog2(WAYS);
  localparam int TAG_W     = ADDR_BITS;
  localparam int AGE_W     = WAY_W;
  localparam int FILL_W    = WAY_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd3;

  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic load;
    logic compute;
    logic commit;
  } sactc_cmd_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            dirty;
    logic [FILL_W-1:0]          fill;
  } sactc_row_t;

endpackage

// ----- src/sactc_if.sv -----
interface sactc_req_if;
  import sactc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, func, address, input ready);
  modport sink   (input valid, func, address, output ready);
endinterface

interface sactc_rsp_if;
  import sactc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             write_back;
  logic [WAY_W-1:0] way_used;
  logic [SET_W-1:0] set_used;
  modport source (output valid, hit, write_back, way_used, set_used, input ready);
  modport sink   (input valid, hit, write_back, way_used, set_used, output ready);
endinterface

// ----- src/sactc_ctrl.sv -----
module sactc_ctrl
  import sactc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output sactc_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.load    = in_valid && in_ready;
  assign cmd.compute = (state_r == ST_CMP);
  // result slot frees up on the same edge it is taken
  assign cmd.commit  = (state_r == ST_WR) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd.load) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_WR;
      ST_WR:   if (cmd.commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/sactc_dpath.sv -----
module sactc_dpath
  import sactc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sactc_cmd_t           cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_func,
  input  logic [ADDR_BITS-1:0] in_address,
  output logic                 out_hit,
  output logic                 out_write_back,
  output logic [WAY_W-1:0]     out_way_used,
  output logic [SET_W-1:0]     out_set_used
);

  logic [CFG_W-1:0] bo_r, sb_r, ways_r;
  logic             lru_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bo_r   <= 4'd4;
      sb_r   <= 4'd6;
      ways_r <= 4'd4;
      lru_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_OFFSET: bo_r   <= cfg_wdata;
        REG_SET_BITS:     sb_r   <= cfg_wdata;
        REG_WAYS:         ways_r <= cfg_wdata;
        REG_POLICY:       lru_r  <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // address split
  logic [CFG_W-1:0]     sb_eff;
  logic [ADDR_BITS-1:0] blk;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;

  always_comb begin
    sb_eff = (sb_r > CFG_W'(SET_W)) ? CFG_W'(SET_W) : sb_r;
    blk    = in_address >> bo_r;
    set_in = SET_W'(blk) & SET_W'(((SET_W+1)'(1) << sb_eff) - (SET_W+1)'(1));
    tag_in = TAG_W'(blk >> sb_eff);
  end

  logic             func_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  sactc_row_t     mem_r [SETS];
  logic [SETS-1:0] row_vld_r;
  sactc_row_t     rd_row_r;
  logic           rd_vld_r;
  sactc_row_t     new_row_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      set_r    <= set_in;
      tag_r    <= tag_in;
      rd_row_r <= mem_r[set_in];
      rd_vld_r <= row_vld_r[set_in];
    end
    if (cmd.commit) mem_r[set_r] <= new_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= '0;
    else if (cmd.commit) row_vld_r[set_r] <= 1'b1;
  end

  // lookup and update
  logic [FILL_W-1:0] n, ways_eff;
  logic              hit, wb, hit_found;
  logic [WAY_W-1:0]  hit_way, vic, way;
  logic [AGE_W-1:0]  mx, a;
  sactc_row_t        nr;

  always_comb begin
    n = rd_vld_r ? rd_row_r.fill : '0;
    if (n > FILL_W'(WAYS)) n = FILL_W'(WAYS);
    ways_eff = (ways_r == '0) ? FILL_W'(1) :
               (ways_r > CFG_W'(WAYS)) ? FILL_W'(WAYS) : FILL_W'(ways_r);
    hit_found = 1'b0;
    hit_way   = '0;
    for (int i = WAYS-1; i >= 0; i--) begin
      if (FILL_W'(i) < n && rd_row_r.tag[i] == tag_r) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
    end
    mx  = '0;
    vic = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (FILL_W'(i) < n && rd_row_r.age[i] > mx) begin
        mx  = rd_row_r.age[i];
        vic = WAY_W'(i);
      end
    end
    nr      = rd_row_r;
    nr.fill = n;
    hit     = hit_found;
    wb      = 1'b0;
    if (hit_found) begin
      way = hit_way;
      a   = rd_row_r.age[way];
      if (lru_r) begin
        for (int j = 0; j < WAYS; j++)
          if (FILL_W'(j) < n && rd_row_r.age[j] < a) nr.age[j] = rd_row_r.age[j] + 1'b1;
        nr.age[way] = '0;
      end
      if (func_r == FUNC_WRITE) nr.dirty[way] = 1'b1;
    end else if (n >= ways_eff) begin
      way = vic;
      a   = rd_row_r.age[way];
      wb  = rd_row_r.dirty[way];
      for (int j = 0; j < WAYS; j++)
        if (FILL_W'(j) < n && rd_row_r.age[j] < a) nr.age[j] = rd_row_r.age[j] + 1'b1;
      nr.age[way]   = '0;
      nr.tag[way]   = tag_r;
      nr.dirty[way] = (func_r == FUNC_WRITE);
    end else begin
      way = WAY_W'(n);
      a   = '0;
      for (int j = 0; j < WAYS; j++)
        if (FILL_W'(j) < n) nr.age[j] = rd_row_r.age[j] + 1'b1;
      nr.age[way]   = '0;
      nr.tag[way]   = tag_r;
      nr.dirty[way] = (func_r == FUNC_WRITE);
      nr.fill       = n + 1'b1;
    end
  end

  logic             res_hit_r, res_wb_r;
  logic [WAY_W-1:0] res_way_r;

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      new_row_r <= nr;
      res_hit_r <= hit;
      res_wb_r  <= wb;
      res_way_r <= way;
    end
  end

  logic             hit_r, wb_r;
  logic [WAY_W-1:0] way_r;
  logic [SET_W-1:0] set_out_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= res_hit_r;
      wb_r      <= res_wb_r;
      way_r     <= res_way_r;
      set_out_r <= set_r;
    end
  end

  assign out_hit        = hit_r;
  assign out_write_back = wb_r;
  assign out_way_used   = way_r;
  assign out_set_used   = set_out_r;

endmodule

// ----- src/set_assoc_cache_tag_controller_top.sv -----
// channel   | dir | handshake     | payload
// in_req    | in  | valid/ready   | func, address
// out_rsp   | out | valid/ready   | hit, write_back, way_used, set_used
// cfg       | in  | cfg_we        | cfg_index, cfg_wdata
// One request at a time, in three steps: accept + set row read, tag compare and
// victim pick, row write-back; a new request is taken only after write-back.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls in its write stage only while that register is full.
// Synchronous reset clears control and the per-set valid bits; no clearing pass.
module set_assoc_cache_tag_controller_top
  import sactc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sactc_req_if.sink            in_req,
  sactc_rsp_if.source          out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  sactc_cmd_t cmd;

  sactc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  sactc_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_req.func),
    .in_address     (in_req.address),
    .out_hit        (out_rsp.hit),
    .out_write_back (out_rsp.write_back),
    .out_way_used   (out_rsp.way_used),
    .out_set_used   (out_rsp.set_used)
  );

endmodule

// ----- src/sactc_chk.sv -----
module sactc_chk
  import sactc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_hit,
  input logic             out_write_back,
  input logic [SET_W-1:0] out_set_used
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_set_used))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result appeared without a request three cycles earlier");

  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_write_back))
    else $error("write-back flagged on a hit");

endmodule

bind set_assoc_cache_tag_controller_top sactc_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_hit        (out_rsp.hit),
  .out_write_back (out_rsp.write_back),
  .out_set_used   (out_rsp.set_used)
);

// ----- verif/tb.sv -----
module tb;
  import sactc_pkg::*;

  typedef struct {
    bit        func;
    bit [31:0] address;
  } access_t;

  typedef struct {
    bit       hit;
    bit       write_back;
    bit [2:0] way_used;
    bit [7:0] set_used;
  } lookup_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  sactc_req_if in_req();
  sactc_rsp_if out_rsp();

  set_assoc_cache_tag_controller_top uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the cache state and registers
  bit [31:0] tag_mem [SETS*WAYS];
  bit        dirty_mem [SETS*WAYS];
  int        age_mem [SETS*WAYS];
  int        fill_mem [SETS];
  int        off_bits = 4;
  int        idx_bits = 6;
  int        ways_reg = 4;
  bit        lru_mode = 1'b1;

  access_t pending_accesses[$];
  lookup_t expected_lookups[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_idle = 0;
  bit      hold_off = 1'b1;
  int      quiet_cycles = 0;
  bit [31:0] hot_addr[12];

  function automatic void age_up_below(int base, int n, int a);
    for (int j = 0; j < n; j++)
      if (age_mem[base+j] < a) age_mem[base+j]++;
  endfunction

  function automatic lookup_t lookup_access(bit wr, bit [31:0] a);
    lookup_t r;
    int sb, nw, n, base, way, mx;
    longint unsigned blk, set, tag;
    bit h;
    sb = (idx_bits > 8) ? 8 : idx_bits;
    nw = (ways_reg == 0) ? 1 : (ways_reg > WAYS ? WAYS : ways_reg);
    blk = 64'(a) >> off_bits;
    set = blk & ((64'd1 << sb) - 1);
    tag = blk >> sb;
    base = int'(set) * WAYS;
    n = fill_mem[set];
    h = 1'b0;
    way = 0;
    r.write_back = 1'b0;
    for (int i = 0; i < n; i++)
      if (!h && tag_mem[base+i] == tag[31:0]) begin
        h = 1'b1;
        way = i;
      end
    if (h) begin
      if (lru_mode) begin
        age_up_below(base, n, age_mem[base+way]);
        age_mem[base+way] = 0;
      end
      if (wr) dirty_mem[base+way] = 1'b1;
    end else if (n >= nw) begin
      mx = 0;
      for (int i = 0; i < n; i++)
        if (age_mem[base+i] > mx) begin
          mx = age_mem[base+i];
          way = i;
        end
      r.write_back = dirty_mem[base+way];
      tag_mem[base+way] = tag[31:0];
      dirty_mem[base+way] = wr;
      age_up_below(base, n, age_mem[base+way]);
      age_mem[base+way] = 0;
    end else begin
      way = n;
      for (int j = 0; j < n; j++) age_mem[base+j] = (age_mem[base+j] + 1) & 15;
      tag_mem[base+way] = tag[31:0];
      dirty_mem[base+way] = wr;
      age_mem[base+way] = 0;
      fill_mem[set] = n + 1;
    end
    r.hit = h;
    r.way_used = way[2:0];
    r.set_used = set[7:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    access_t acc;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        expected_lookups.push_back(lookup_access(in_req.func, in_req.address));
      end
      if (!in_req.valid || in_req.ready) begin
        if (pending_accesses.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
          acc = pending_accesses.pop_front();
          in_req.valid <= 1'b1;
          in_req.func <= acc.func;
          in_req.address <= acc.address;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_t e;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected response");
          errors++;
        end else begin
          e = expected_lookups.pop_front();
          if (out_rsp.hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, out_rsp.hit);
            errors++;
          end
          if (out_rsp.write_back !== e.write_back) begin
            $error("write_back expected %0d actual %0d", e.write_back, out_rsp.write_back);
            errors++;
          end
          if (out_rsp.way_used !== e.way_used) begin
            $error("way_used expected %0d actual %0d", e.way_used, out_rsp.way_used);
            errors++;
          end
          if (out_rsp.set_used !== e.set_used) begin
            $error("set_used expected %0d actual %0d", e.set_used, out_rsp.set_used);
            errors++;
          end
        end
      end
      out_rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_access(bit f, bit [31:0] a);
    access_t acc;
    acc.func = f;
    acc.address = a;
    pending_accesses.push_back(acc);
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() > 0 || in_req.valid || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLOCK_OFFSET: off_bits = val & 15;
      REG_SET_BITS:     idx_bits = val & 15;
      REG_WAYS:         ways_reg = val & 15;
      default:          lru_mode = val[0];
    endcase
  endtask

  function automatic bit [31:0] conflict_addr(int setsel);
    longint unsigned t;
    int sh;
    sh = off_bits + ((idx_bits > 8) ? 8 : idx_bits);
    t = {32'($urandom), 32'($urandom)};
    return 32'((t << sh) | (64'(setsel) << off_bits));
  endfunction

  int phase_cfg[8][4] = '{
    '{4, 6, 4, 1}, '{0, 0, 8, 1}, '{12, 8, 1, 0}, '{15, 15, 0, 1},
    '{2, 3, 8, 0}, '{5, 2, 2, 1}, '{3, 1, 15, 0}, '{13, 4, 3, 1}
  };

  initial begin
    bit [31:0] a;
    int k;
    in_req.valid = 1'b0;
    in_req.func = 1'b0;
    in_req.address = '0;
    out_rsp.ready = 1'b0;
    for (int i = 0; i < SETS; i++) fill_mem[i] = 0;
    for (int i = 0; i < SETS*WAYS; i++) begin
      dirty_mem[i] = 1'b0;
      age_mem[i] = 0;
      tag_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, hit, dirty hit, fills, dirty eviction, LRU refresh
    send_idle = 37;
    recv_idle = 69;
    push_access(1'b0, 32'h0);
    push_access(FUNC_WRITE, 32'h0);
    push_access(1'b0, 32'hFFFF_FFFF);
    push_access(FUNC_WRITE, 32'hFFFF_FFFF);
    for (int i = 1; i <= 5; i++) push_access(FUNC_WRITE, i << 10);
    push_access(1'b0, 32'd3 << 10);
    push_access(1'b0, 32'd7 << 10);
    push_access(1'b0, 32'd8 << 10);
    push_access(1'b0, 32'h0);
    push_access(FUNC_WRITE, 32'h8000_0000);
    push_access(1'b0, 32'h7FFF_FFF0);
    hold_off = 1'b0;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_BLOCK_OFFSET, phase_cfg[p][0]);
      write_reg(REG_SET_BITS, phase_cfg[p][1]);
      write_reg(REG_WAYS, phase_cfg[p][2]);
      write_reg(REG_POLICY, phase_cfg[p][3]);
      send_idle = (p < 3) ? 37 : (p < 6 ? 69 : 0);
      recv_idle = (p < 3) ? 69 : (p < 6 ? 37 : 0);
      for (int i = 0; i < 12; i++) hot_addr[i] = conflict_addr(i % 3);
      for (int i = 0; i < 125; i++) begin
        k = $urandom_range(11);
        if ($urandom_range(99) < 75) begin
          a = hot_addr[k] ^ (32'($urandom) & ((32'd1 << off_bits) - 1));
        end else begin
          a = $urandom;
          if ($urandom_range(9) == 0) hot_addr[k] = conflict_addr($urandom_range(2));
        end
        push_access(1'($urandom_range(1)), a);
      end
      wait_drained();
    end

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
